// ===== src/lsmpq_pkg.sv =====
// ----------------------------------------------------------------------------
// lsmpq_pkg: shared types and constants
// Entry layout, status and op codes, sequencer states and the control
// bundle that drives the running-minimum unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsmpq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 56;

  typedef struct packed {
    logic signed [31:0] prio;
    logic [7:0]         kind;
    logic [15:0]        ref_idx;
  } entry_t;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    logic              clear;
    logic              load;
    logic [ADDR_W-1:0] idx;
  } min_ctl_t;

endpackage

`default_nettype wire

// ===== src/lsmpq_ram.sv =====
// ----------------------------------------------------------------------------
// lsmpq_ram: entry store
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsmpq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 56
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lsmpq_min_unit.sv =====
// ----------------------------------------------------------------------------
// lsmpq_min_unit: running minimum
// Shared signed comparator; holds the smallest entry seen and its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsmpq_min_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lsmpq_pkg::min_ctl_t          ctl,
  input  wire lsmpq_pkg::entry_t            cand,
  output lsmpq_pkg::entry_t                 best,
  output logic [lsmpq_pkg::ADDR_W-1:0]      best_idx
);

  lsmpq_pkg::entry_t                best_r;
  logic [lsmpq_pkg::ADDR_W-1:0]     best_idx_r;
  logic                             have_r;
  logic                             take;

  // strict less keeps the earliest among equal keys
  assign take = ctl.load && (!have_r || (cand.prio < best_r.prio));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (ctl.load) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_r     <= cand;
      best_idx_r <= ctl.idx;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule

`default_nettype wire

// ===== src/linear_scan_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// linear_scan_min_priority_queue: unsorted store with extract-min
// Push appends; pop scans for the smallest signed 16.16 priority, returns it
// and closes the gap by moving later entries down one place.
// ----------------------------------------------------------------------------
// Usage: pulse start with busy low to transfer one command. Every command
// gives exactly one result, shown for one cycle with out_valid high; the
// receiver cannot stall it, so capture it when out_valid is seen. A push, a
// push on full and a pop on empty finish at once: the result appears in the
// next cycle and busy stays low, so commands of that kind may follow back to
// back. A pop keeps busy high while it scans the store (one read a cycle,
// then a step to compare the last entry and a step to settle the minimum)
// and then moves the entries after the popped one down one place; nothing
// is moved when the popped entry was the last one. The single read port
// of the entry store yields one entry per cycle to the shared comparator
// and then to the move-down pass. The result is shown in the first cycle
// in which busy is low again. The store needs no clearing after reset:
// only positions below the entry count are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_min_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [31:0] in_prio_in,
  input  wire logic [7:0]  in_kind_in,
  input  wire logic [15:0] in_ref_in,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_prio_out,
  output logic [7:0]       out_kind_out,
  output logic [15:0]      out_ref_out,
  output logic             out_now_empty
);

  localparam int AW = lsmpq_pkg::ADDR_W;
  localparam int CW = lsmpq_pkg::CNT_W;

  // Sequencer state
  lsmpq_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;       // next address to read
  logic              pend_r, pend_nxt;     // read data arrives this cycle
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;

  // Result registers
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic              out_now_empty_r, out_now_empty_nxt;
  lsmpq_pkg::entry_t out_entry_r, out_entry_nxt;

  // Store ports
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  lsmpq_pkg::entry_t ram_wdata, ram_rdata;

  // Min unit
  lsmpq_pkg::min_ctl_t min_ctl;
  lsmpq_pkg::entry_t   best;
  logic [AW-1:0]       best_idx;

  logic accept;
  logic full;

  assign accept = start && (state_r == lsmpq_pkg::S_IDLE);
  assign full   = (count_r == CW'(lsmpq_pkg::CAPACITY));

  lsmpq_ram #(
    .DEPTH (lsmpq_pkg::CAPACITY),
    .WIDTH (lsmpq_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lsmpq_min_unit u_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (min_ctl),
    .cand     (ram_rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsmpq_pkg::S_IDLE;
      count_r     <= '0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r      <= pend_idx_nxt;
    out_status_r    <= out_status_nxt;
    out_now_empty_r <= out_now_empty_nxt;
    out_entry_r     <= out_entry_nxt;
  end

  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    ptr_nxt           = ptr_r;
    pend_nxt          = 1'b0;
    pend_idx_nxt      = ptr_r[AW-1:0];
    out_valid_nxt     = 1'b0;
    out_status_nxt    = out_status_r;
    out_now_empty_nxt = out_now_empty_r;
    out_entry_nxt     = out_entry_r;
    ram_we            = 1'b0;
    ram_waddr         = count_r[AW-1:0];
    ram_wdata         = '{prio: in_prio_in, kind: in_kind_in, ref_idx: in_ref_in};
    ram_re            = 1'b0;
    ram_raddr         = ptr_r[AW-1:0];
    min_ctl           = '{clear: 1'b0, load: 1'b0, idx: pend_idx_r};

    case (state_r)
      lsmpq_pkg::S_IDLE: begin
        if (accept) begin
          out_entry_nxt = '0;
          if (in_op == lsmpq_pkg::OP_PUSH) begin
            // Append at the tail, or drop when full
            out_valid_nxt = 1'b1;
            if (full) begin
              out_status_nxt    = lsmpq_pkg::ST_FULL;
              out_now_empty_nxt = 1'b0;
            end else begin
              ram_we            = 1'b1;
              count_nxt         = count_r + CW'(1);
              out_status_nxt    = lsmpq_pkg::ST_PUSHED;
              out_now_empty_nxt = 1'b0;
            end
          end else if (count_r == '0) begin
            out_valid_nxt     = 1'b1;
            out_status_nxt    = lsmpq_pkg::ST_EMPTY;
            out_now_empty_nxt = 1'b1;
          end else begin
            // Start the scan from position zero
            min_ctl.clear = 1'b1;
            ptr_nxt       = '0;
            state_nxt     = lsmpq_pkg::S_SCAN;
          end
        end
      end

      lsmpq_pkg::S_SCAN: begin
        // Issue one read a cycle; compare the entry that returns
        if (ptr_r < count_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
        end
        min_ctl.load = pend_r;
        if ((ptr_r == count_r) && !pend_r) begin
          // Minimum settled: move later entries down from just past it
          ptr_nxt   = CW'(best_idx) + CW'(1);
          state_nxt = lsmpq_pkg::S_SHIFT;
        end
      end

      lsmpq_pkg::S_SHIFT: begin
        if (ptr_r < count_r) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + CW'(1);
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_idx_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if ((ptr_r == count_r) && !pend_r) begin
          count_nxt         = count_r - CW'(1);
          out_valid_nxt     = 1'b1;
          out_status_nxt    = lsmpq_pkg::ST_POPPED;
          out_now_empty_nxt = (count_r == CW'(1));
          out_entry_nxt     = best;
          state_nxt         = lsmpq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lsmpq_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_r != lsmpq_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_prio_out  = out_entry_r.prio;
  assign out_kind_out  = out_entry_r.kind;
  assign out_ref_out   = out_entry_r.ref_idx;
  assign out_now_empty = out_now_empty_r;

`ifndef ASSERT_OFF
  // A pop that ends always shows its result in the same cycle that busy falls
  a_pop_ends_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("pop finished without a result");

  // Entry count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(lsmpq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A popped result removes exactly one entry
  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == lsmpq_pkg::ST_POPPED))
      |-> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove one entry");

  // A pop of a non-empty store enters the scan
  a_pop_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == lsmpq_pkg::OP_POP) && (count_r != '0)) |=> busy)
    else $error("pop of non-empty store did not start a scan");

  // Reported emptiness agrees with the count
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_now_empty_r == (count_r == '0)))
    else $error("now_empty disagrees with entry count");
`endif

endmodule

`default_nettype wire
